/* rtl/i2a_pkg.sv */
// shared types, constants and glyph lookup for the integer to ascii formatter
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned NIBBLES   = 20;
  localparam int unsigned DIG_W     = NIBBLES * 4;
  localparam int unsigned DEC_STEPS = VALUE_W;

  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_H     = 8'h48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_DIGIT,
    ST_SUFFIX
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_DEC,
    OP_LOAD_HEX,
    OP_DABBLE,
    OP_SHIFT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic neg;
  } dp_cmd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
    logic       last;
  } emit_t;

  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] code;
    if (nib < 4'd10) begin
      code = CHAR_ZERO + {4'd0, nib};
    end else begin
      code = CHAR_A + {4'd0, nib - 4'd10};
    end
    return code;
  endfunction

endpackage

/* rtl/integer_to_ascii_formatter_top.sv */
// top level of the integer to ascii formatter with output register
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i, in_stall_o | value_i[63:0], kind_i[1:0]
//  out     | output    | out_valid_o, out_stall_i | char_code_o[7:0], last_o
//
//  decimal: accept, 64 double-dabble steps, the sign if negative, up to 19 leading
//  zero skips, then the digits, one character per cycle while the output is free
//  hex: accept, up to 19 leading zero skips, then the digits, one per cycle while
//  the output is free, then the suffix
//  the 64-step binary to bcd loop runs through the shared add-3 unit
//  reset clears the sequencer and the output valid; no clearing pass
//  a stalled output holds the character and freezes emission; the next
//  transaction is taken as soon as the last character sits in the output register

module integer_to_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  input  logic [1:0]  kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_code_o,
  output logic        last_o
);

  i2a_pkg::dp_cmd_t cmd;
  i2a_pkg::emit_t   emit;
  logic [3:0]       top_nibble;
  logic             out_free;

  logic       out_valid_q;
  logic [7:0] char_q;
  logic       last_q;

  // output register can take a character when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  i2a_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .kind_i       (kind_i),
    .value_msb_i  (value_i[63]),
    .in_stall_o   (in_stall_o),
    .out_free_i   (out_free),
    .top_nibble_i (top_nibble),
    .cmd_o        (cmd),
    .emit_o       (emit)
  );

  i2a_digit_unit u_digit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (value_i),
    .top_nibble_o (top_nibble)
  );

  // output valid, control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      char_q <= emit.char_code;
      last_q <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

`ifndef SYNTH
  // a transaction taken leaves the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after input transaction");

  // no character is produced while the output register is full and stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> out_free)
    else $error("character emitted into a stalled output register");

  // the final character returns the sequencer to idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit.last) |=> !in_stall_o)
    else $error("sequencer not idle after final character");

  // nothing is emitted while an input is still free to enter
  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !emit.valid)
    else $error("character emitted while idle");
`endif

endmodule

/* rtl/i2a_digit_unit.sv */
// shared shift and add-3 unit holding the binary operand and the digit register
`timescale 1ns / 1ps

module i2a_digit_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  i2a_pkg::dp_cmd_t                    cmd_i,
  input  logic [i2a_pkg::VALUE_W-1:0]         value_i,
  output logic [3:0]                          top_nibble_o
);

  logic [i2a_pkg::VALUE_W-1:0] bin_q, bin_d;
  logic [i2a_pkg::DIG_W-1:0]   dig_q, dig_d;
  logic [i2a_pkg::DIG_W-1:0]   dig_adj;

  // add 3 to every bcd digit of five or more ahead of the shift
  always_comb begin
    for (int i = 0; i < int'(i2a_pkg::NIBBLES); i++) begin
      if (dig_q[i*4 +: 4] >= 4'd5) begin
        dig_adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
      end else begin
        dig_adj[i*4 +: 4] = dig_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    dig_d = dig_q;
    unique case (cmd_i.op)
      i2a_pkg::OP_HOLD: begin
      end
      i2a_pkg::OP_LOAD_DEC: begin
        bin_d = cmd_i.neg ? (~value_i + 1'b1) : value_i;
        dig_d = '0;
      end
      i2a_pkg::OP_LOAD_HEX: begin
        dig_d = {{(i2a_pkg::DIG_W - i2a_pkg::VALUE_W){1'b0}}, value_i};
      end
      i2a_pkg::OP_DABBLE: begin
        dig_d = {dig_adj[i2a_pkg::DIG_W-2:0], bin_q[i2a_pkg::VALUE_W-1]};
        bin_d = {bin_q[i2a_pkg::VALUE_W-2:0], 1'b0};
      end
      i2a_pkg::OP_SHIFT: begin
        dig_d = {dig_q[i2a_pkg::DIG_W-5:0], 4'd0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      dig_q <= '0;
    end else begin
      bin_q <= bin_d;
      dig_q <= dig_d;
    end
  end

  assign top_nibble_o = dig_q[i2a_pkg::DIG_W-1 -: 4];

endmodule

/* rtl/i2a_ctrl.sv */
// sequencer: conversion steps, leading zero skip and character emission
`timescale 1ns / 1ps

module i2a_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       kind_i,
  input  logic             value_msb_i,
  output logic             in_stall_o,
  input  logic             out_free_i,
  input  logic [3:0]       top_nibble_i,
  output i2a_pkg::dp_cmd_t cmd_o,
  output i2a_pkg::emit_t   emit_o
);

  localparam int unsigned StepW = $clog2(i2a_pkg::DEC_STEPS);
  localparam int unsigned CntW  = $clog2(i2a_pkg::NIBBLES + 1);
  localparam logic [StepW-1:0] StepLast = StepW'(i2a_pkg::DEC_STEPS - 1);
  localparam logic [CntW-1:0]  CntFull  = CntW'(i2a_pkg::NIBBLES);
  localparam logic [CntW-1:0]  CntOne   = CntW'(1);

  i2a_pkg::state_e  state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             hex_q, hex_d;
  logic             neg_q, neg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2a_pkg::ST_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      hex_q   <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      hex_q   <= hex_d;
      neg_q   <= neg_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    hex_d      = hex_q;
    neg_d      = neg_q;
    in_stall_o = 1'b1;
    cmd_o      = '{op: i2a_pkg::OP_HOLD, neg: 1'b0};
    emit_o     = '{valid: 1'b0, char_code: 8'd0, last: 1'b0};
    unique case (state_q)
      i2a_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          hex_d = kind_i[1];
          neg_d = (kind_i == i2a_pkg::KIND_SDEC) && value_msb_i;
          cnt_d = CntFull;
          if (kind_i[1]) begin
            cmd_o.op = i2a_pkg::OP_LOAD_HEX;
            state_d  = i2a_pkg::ST_SKIP;
          end else begin
            cmd_o.op  = i2a_pkg::OP_LOAD_DEC;
            cmd_o.neg = (kind_i == i2a_pkg::KIND_SDEC) && value_msb_i;
            step_d    = '0;
            state_d   = i2a_pkg::ST_CONV;
          end
        end
      end
      i2a_pkg::ST_CONV: begin
        cmd_o.op = i2a_pkg::OP_DABBLE;
        step_d   = step_q + 1'b1;
        if (step_q == StepLast) begin
          state_d = neg_q ? i2a_pkg::ST_SIGN : i2a_pkg::ST_SKIP;
        end
      end
      i2a_pkg::ST_SIGN: begin
        if (out_free_i) begin
          emit_o  = '{valid: 1'b1, char_code: i2a_pkg::CHAR_MINUS, last: 1'b0};
          state_d = i2a_pkg::ST_SKIP;
        end
      end
      i2a_pkg::ST_SKIP: begin
        // drop leading zeros, always keep the final digit
        if ((top_nibble_i == 4'd0) && (cnt_q != CntOne)) begin
          cmd_o.op = i2a_pkg::OP_SHIFT;
          cnt_d    = cnt_q - 1'b1;
        end else begin
          state_d = i2a_pkg::ST_DIGIT;
        end
      end
      i2a_pkg::ST_DIGIT: begin
        if (out_free_i) begin
          emit_o = '{valid: 1'b1, char_code: i2a_pkg::glyph(top_nibble_i),
                     last: (cnt_q == CntOne) && !hex_q};
          cmd_o.op = i2a_pkg::OP_SHIFT;
          cnt_d    = cnt_q - 1'b1;
          if (cnt_q == CntOne) begin
            state_d = hex_q ? i2a_pkg::ST_SUFFIX : i2a_pkg::ST_IDLE;
          end
        end
      end
      i2a_pkg::ST_SUFFIX: begin
        if (out_free_i) begin
          emit_o  = '{valid: 1'b1, char_code: i2a_pkg::CHAR_H, last: 1'b1};
          state_d = i2a_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i2a_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* bench/tb_top.sv */
// self-checking bench for the integer to ascii formatter: directed and random values, all kinds
`timescale 1ns / 1ps

module tb_top;

  // kind codes beyond the two decimal ones in the package
  localparam logic [1:0] KIND_HEX     = 2'd2;
  localparam logic [1:0] KIND_HEX_ALT = 2'd3;  // only bit 1 is decoded, so also hex

  localparam string GLYPHS     = "0123456789ABCDEF";
  localparam int    IDLE_LIMIT = 3000;  // covers the longest item plus stalls and gaps
  localparam int    DRAIN_WAIT = 150;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] value_i;
  logic [1:0]  kind_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  char_code_o;
  logic        last_o;

  char_t pending_chars[$];  // characters still owed by the block, oldest first
  int    mismatches = 0;
  int    burst_left;
  int    stall_left = 0;
  bit    stall_hold = 1'b0;
  bit    idling_on;
  int    idle_cycles = 0;

  integer_to_ascii_formatter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // builds the text of one value and queues it as expected characters
  function automatic void predict_text(input logic [63:0] v, input logic [1:0] k);
    logic [7:0]  digits_rev[$];
    logic [7:0]  text[$];
    logic [63:0] mag;
    char_t       c;
    mag = v;
    if (k[1]) begin
      // hex: nibbles low first, reversed below, then the suffix
      do begin
        digits_rev.push_back(GLYPHS[int'(mag[3:0])]);
        mag = mag >> 4;
      end while (mag != 64'd0);
    end else begin
      // negative signed value: sign, then the magnitude taken modulo 2^64
      if (k == i2a_pkg::KIND_SDEC && v[63]) begin
        text.push_back(i2a_pkg::CHAR_MINUS);
        mag = 64'd0 - v;
      end
      do begin
        digits_rev.push_back(GLYPHS[int'(mag % 64'd10)]);
        mag = mag / 64'd10;
      end while (mag != 64'd0);
    end
    while (digits_rev.size() > 0) text.push_back(digits_rev.pop_back());
    if (k[1]) text.push_back(i2a_pkg::CHAR_H);
    foreach (text[i]) begin
      c.code = text[i];
      c.last = (i == text.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // random operand whose set bits stay below the given width
  function automatic logic [63:0] random_operand(input int width);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    if (width < 64) r &= (64'd1 << width) - 64'd1;
    return r;
  endfunction

  // one transaction on the input channel; gaps come between bursts when idling is on
  task automatic send_number(input logic [63:0] v, input logic [1:0] k);
    int gap;
    @(negedge clk_i);
    if (idling_on && burst_left == 0) begin
      in_valid_i = 1'b0;
      // mostly short gaps, now and then one long enough to land mid-conversion
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i = 1'b1;
    value_i    = v;
    kind_i     = k;
    do @(posedge clk_i); while (in_stall_o);
    predict_text(v, k);
  endtask

  // receiver stall pattern: runs of ready and stalled cycles of random length
  always @(negedge clk_i) begin
    if (!idling_on) begin
      out_stall_i = 1'b0;
      stall_left  = 0;
    end else begin
      if (stall_left == 0) begin
        stall_hold = ($urandom_range(0, 2) == 0);
        stall_left = stall_hold ? $urandom_range(1, 12) : $urandom_range(1, 20);
      end
      stall_left--;
      out_stall_i = stall_hold;
    end
  end

  // compares every character transaction against the oldest expectation
  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected character: expected none, actual code %h last %b",
                 $time, char_code_o, last_o);
      end else begin
        want = pending_chars.pop_front();
        if (char_code_o !== want.code) begin
          mismatches++;
          $display("%0t: char_code mismatch: expected %h, actual %h",
                   $time, want.code, char_code_o);
        end
        if (last_o !== want.last) begin
          mismatches++;
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last_o);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // zero gives a single digit in every kind
  task automatic test_zero();
    send_number(64'd0, i2a_pkg::KIND_UDEC);
    send_number(64'd0, i2a_pkg::KIND_SDEC);
    send_number(64'd0, KIND_HEX);
    send_number(64'd0, KIND_HEX_ALT);
  endtask

  // longest texts and the signed limits
  task automatic test_extremes();
    send_number({64{1'b1}}, i2a_pkg::KIND_UDEC);
    send_number({64{1'b1}}, i2a_pkg::KIND_SDEC);
    send_number({64{1'b1}}, KIND_HEX);
    send_number({64{1'b1}}, KIND_HEX_ALT);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, i2a_pkg::KIND_SDEC);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, i2a_pkg::KIND_UDEC);
    send_number(64'd1, i2a_pkg::KIND_SDEC);
  endtask

  // most negative value must print with its full magnitude
  task automatic test_most_negative();
    send_number(64'h8000_0000_0000_0000, i2a_pkg::KIND_SDEC);
    send_number(64'h8000_0000_0000_0000, i2a_pkg::KIND_UDEC);
    send_number(64'h8000_0000_0000_0000, KIND_HEX);
  endtask

  // digit count changes and the unused kind with a letter digit
  task automatic test_digit_boundaries();
    send_number(64'd9, i2a_pkg::KIND_UDEC);
    send_number(64'd10, i2a_pkg::KIND_UDEC);
    send_number(64'd15, KIND_HEX);
    send_number(64'd16, KIND_HEX);
    send_number(64'd9999999999999999999, i2a_pkg::KIND_UDEC);
    send_number(64'd10000000000000000000, i2a_pkg::KIND_UDEC);
    send_number(-64'sd10, i2a_pkg::KIND_SDEC);
    send_number(64'hABCD_EF01_2345_6789, KIND_HEX_ALT);
  endtask

  // random widths and kinds with gaps and stalls
  task automatic test_random_bursts(input int count);
    idling_on = 1'b1;
    repeat (count) begin
      send_number(random_operand($urandom_range(0, 64)), 2'($urandom_range(0, 3)));
    end
  endtask

  // back to back transactions with the receiver always ready
  task automatic test_random_back_to_back(input int count);
    idling_on = 1'b0;
    repeat (count) begin
      send_number(random_operand($urandom_range(0, 64)), 2'($urandom_range(0, 3)));
    end
  endtask

  // full 64-bit patterns, so every bit and the sign bit toggle often
  task automatic test_random_full_width(input int count);
    idling_on = 1'b1;
    repeat (count) begin
      send_number(random_operand(64), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    kind_i      = i2a_pkg::KIND_UDEC;
    burst_left  = 0;
    idling_on   = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part runs without idling
    test_zero();
    test_extremes();
    test_most_negative();
    test_digit_boundaries();

    test_random_bursts(200);
    test_random_back_to_back(60);
    test_random_full_width(70);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    idling_on  = 1'b0;

    // wait for every owed character, then watch for stray output
    while (pending_chars.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* integer_to_ascii_formatter_top.f */
rtl/i2a_pkg.sv
rtl/i2a_digit_unit.sv
rtl/i2a_ctrl.sv
rtl/integer_to_ascii_formatter_top.sv
bench/tb_top.sv
